FILE: rtl/rce_pkg.sv
// rce_pkg: shared types and constants for the character modexp pipeline.
// No dependencies; used by every module under rtl.
`default_nettype none
package rce_pkg;
    localparam int MOD_BITS = 16;
    localparam int EXP_BITS = 16;
    localparam int SYM_BITS = 8;
    localparam int CFG_W    = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
    localparam int OUT_W    = ((MOD_BITS + 7) / 8) * 8;
    localparam int IDX_W    = 8;
    localparam int SHIFT_W  = $clog2(SYM_BITS);

    localparam logic [IDX_W-1:0] REG_EXPONENT = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_MODULUS  = IDX_W'(1);

    localparam logic [EXP_BITS-1:0] EXP_RST = EXP_BITS'(1);
    localparam logic [MOD_BITS-1:0] MOD_RST = MOD_BITS'(32'd65535);

    // base: reduced symbol, acc: running power, part: product being built
    typedef struct packed {
        logic [MOD_BITS-1:0] base;
        logic [MOD_BITS-1:0] acc;
        logic [MOD_BITS-1:0] part;
    } t_stage;
endpackage
`default_nettype wire

FILE: rtl/rce_red_cell.sv
// rce_red_cell: one restoring step of symbol mod modulus.
// Depends on rce_pkg.
`default_nettype none
module rce_red_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  rce_pkg::t_stage              i_stage,
    input  wire [rce_pkg::SHIFT_W-1:0]   i_shift,
    input  wire [rce_pkg::MOD_BITS-1:0]  i_mod,
    output logic                         o_valid,
    output rce_pkg::t_stage              o_stage
);
    localparam int W = rce_pkg::MOD_BITS + rce_pkg::SYM_BITS;

    logic [W-1:0]    w_rem;
    logic [W-1:0]    w_div;
    rce_pkg::t_stage n_stage;
    rce_pkg::t_stage r_stage;
    logic            r_valid;

    always_comb begin
        w_rem = {{rce_pkg::SYM_BITS{1'b0}}, i_stage.base};
        w_div = {{rce_pkg::SYM_BITS{1'b0}}, i_mod} << i_shift;
        n_stage = i_stage;
        if (w_rem >= w_div) begin
            n_stage.base = rce_pkg::MOD_BITS'(w_rem - w_div);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule
`default_nettype wire

FILE: rtl/rce_mul_cell.sv
// rce_mul_cell: one MSB-first step of interleaved modular multiplication.
// Depends on rce_pkg.
`default_nettype none
module rce_mul_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  rce_pkg::t_stage              i_stage,
    input  wire                          i_bit,
    input  wire [rce_pkg::MOD_BITS-1:0]  i_mod,
    output logic                         o_valid,
    output rce_pkg::t_stage              o_stage
);
    localparam int W = rce_pkg::MOD_BITS + 1;

    logic [W-1:0]    w_dbl;
    logic [W-1:0]    w_red;
    logic [W-1:0]    w_sum;
    logic [W-1:0]    w_m;
    rce_pkg::t_stage n_stage;
    rce_pkg::t_stage r_stage;
    logic            r_valid;

    // part <- (2*part + bit*acc) mod m, both terms kept below m
    always_comb begin
        w_m   = {1'b0, i_mod};
        w_dbl = {i_stage.part, 1'b0};
        w_red = (w_dbl >= w_m) ? w_dbl - w_m : w_dbl;
        w_sum = w_red + (i_bit ? {1'b0, i_stage.acc} : {W{1'b0}});
        if (w_sum >= w_m) begin
            w_sum = w_sum - w_m;
        end
        n_stage      = i_stage;
        n_stage.part = w_sum[rce_pkg::MOD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule
`default_nettype wire

FILE: rtl/rsa_char_modexp.sv
// rsa_char_modexp: symbol^exponent mod modulus as a chain of cells.
// Depends on rce_pkg, rce_red_cell, rce_mul_cell.
//
// channel | dir | handshake               | payload
// s_*     | in  | s_tvalid / s_tready     | s_tdata[7:0] symbol
// m_*     | out | m_tvalid / m_tready     | m_tdata residue (zero filled)
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; the chain holds one cell
// per multiplier bit for every square and multiply, after the reduction cells.
// The whole chain advances together; it holds when m_tvalid is high and
// m_tready low. Reset clears all valid bits; registers reset to exponent 1
// and modulus 65535.
`default_nettype none
module rsa_char_modexp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [rce_pkg::SYM_BITS-1:0]  s_tdata,   // [7:0] symbol
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [rce_pkg::OUT_W-1:0]    m_tdata,   // [MOD_BITS-1:0] residue
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [rce_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire [rce_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int MB    = rce_pkg::MOD_BITS;
    localparam int NRED  = rce_pkg::SYM_BITS;
    localparam int NPH   = 2 * rce_pkg::EXP_BITS;
    localparam int NSTG  = NRED + NPH * MB;

    logic [rce_pkg::EXP_BITS-1:0] r_exp;
    logic [MB-1:0]                r_mod;
    rce_pkg::t_stage              w_stage [NSTG+1];
    logic                         w_valid [NSTG+1];
    logic                         w_en;
    logic [MB-1:0]                w_one;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= rce_pkg::EXP_RST;
            r_mod <= rce_pkg::MOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rce_pkg::REG_EXPONENT: r_exp <= i_cfg_data[rce_pkg::EXP_BITS-1:0];
                rce_pkg::REG_MODULUS:  r_mod <= i_cfg_data[MB-1:0];
                default: ;
            endcase
        end
    end

    assign w_en     = !w_valid[NSTG] || m_tready;
    assign s_tready = w_en;
    assign w_one    = (r_mod == MB'(1)) ? '0 : MB'(1);

    always_comb begin
        w_valid[0]      = s_tvalid;
        w_stage[0].base = MB'(s_tdata);
        w_stage[0].acc  = '0;
        w_stage[0].part = '0;
    end

    for (genvar g = 0; g < NRED; g++) begin : g_red
        rce_red_cell u_red (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .i_shift (rce_pkg::SHIFT_W'(NRED - 1 - g)),
            .i_mod   (r_mod),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    for (genvar p = 0; p < NPH; p++) begin : g_ph
        for (genvar j = 0; j < MB; j++) begin : g_bit
            localparam int X  = NRED + p * MB + j;
            localparam int EB = rce_pkg::EXP_BITS - 1 - p / 2;
            rce_pkg::t_stage w_in;
            logic [MB-1:0]   w_mult;
            always_comb begin
                w_in = w_stage[X];
                if (j == 0) begin
                    // new product: the previous result becomes the accumulator
                    w_in.acc  = (p == 0) ? w_one : w_stage[X].part;
                    w_in.part = '0;
                end
                if (p % 2 == 0) begin
                    w_mult = w_in.acc;
                end else begin
                    w_mult = r_exp[EB] ? w_in.base : w_one;
                end
            end
            rce_mul_cell u_mul (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_valid[X]),
                .i_stage (w_in),
                .i_bit   (w_mult[MB-1-j]),
                .i_mod   (r_mod),
                .o_valid (w_valid[X+1]),
                .o_stage (w_stage[X+1])
            );
        end
    end

    assign m_tvalid = w_valid[NSTG];
    assign m_tdata  = rce_pkg::OUT_W'((r_mod == '0) ? '0 : w_stage[NSTG].part);

    a_zero_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_mod == '0) |-> m_tdata == '0)
        else $error("residue not zero for zero modulus");
    a_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_mod != '0) |-> m_tdata < rce_pkg::OUT_W'(r_mod))
        else $error("residue not below modulus");
    a_rst_idle: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !m_tvalid)
        else $error("result valid right after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("chain advanced under stall");
endmodule
`default_nettype wire
